// ----- hw/rtl/mapf_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the multichannel allpass filter
// no dependencies

package mapf_pkg;

    // channel field is one bit wide, so two histories are kept
    localparam int CHANNELS     = 2;
    localparam int CH_BITS      = 1;

    // configuration port
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int COEF_BITS    = 16;
    localparam int COEF_FRAC    = 15;
    localparam int DELAY_BITS   = 13;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_COEFFICIENT  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DELAY_LENGTH = 2'd1;

    // reset values
    localparam logic [COEF_BITS-1:0]  COEF_RESET  = 16'd16384;
    localparam logic [DELAY_BITS-1:0] DELAY_RESET = 13'd1;

    typedef logic signed [COEF_BITS-1:0] t_coef;
    typedef logic [DELAY_BITS-1:0]       t_delay;

endpackage

// ----- hw/rtl/multichannel_allpass_filter_top.sv -----
`timescale 1ns / 1ps
// A result passes the compute stage registers, then the output register, to m_axis.
// Throughput: one request per cycle if m_axis is ready; the per-sample loop (subtract,
// multiply, round, add, saturate) is one stage with the last history write forwarded.
// History memory: one read port at accept, one write port at the compute stage.
// Reset: control registers and per-channel fill tracking clear at once; history reads
// as zero until written, so no clearing pass is needed and requests are taken at once.
// depends on mapf_pkg

module multichannel_allpass_filter_top
    import mapf_pkg::*;
#(
    parameter int MAX_DELAY   = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input stream
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // tdata: [SAMPLE_BITS-1:0] sample_in, rest zero
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // tuser: [0] channel
    input  logic [CH_BITS-1:0]       s_axis_tuser,
    // output stream
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // tdata: [SAMPLE_BITS-1:0] sample_out, rest zero
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
    // tuser: [0] channel_out
    output logic [CH_BITS-1:0]       m_axis_tuser,
    // configuration writes
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int SB    = SAMPLE_BITS;
    localparam int TDW   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int AW    = $clog2(MAX_DELAY);
    localparam int CW    = (AW + 1 > DELAY_BITS) ? AW + 1 : DELAY_BITS;
    localparam int MAW   = CH_BITS + AW;
    localparam int DEPTH = 1 << MAW;
    localparam int PW    = SB + COEF_BITS + 1;

    localparam logic [CW-1:0]        D_ONE  = CW'(1);
    localparam logic [CW-1:0]        D_MAX  = CW'(MAX_DELAY);
    localparam logic [CW:0]          S_MAX  = (CW+1)'(MAX_DELAY);
    localparam logic [AW-1:0]        WP_TOP = AW'(MAX_DELAY - 1);
    localparam logic signed [PW-1:0] RND    = PW'(1) << (COEF_FRAC - 1);

    // configuration registers
    t_coef  r_coef;
    t_delay r_delay;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef  <= COEF_RESET;
            r_delay <= DELAY_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_COEFFICIENT:  r_coef  <= i_cfg_data[COEF_BITS-1:0];
                REG_DELAY_LENGTH: r_delay <= i_cfg_data[DELAY_BITS-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic r_b_vld;
    logic r_o_vld;
    logic s_fire;
    logic b_fire;

    assign b_fire        = r_b_vld && (!r_o_vld || m_axis_tready);
    assign s_axis_tready = !r_b_vld || b_fire;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // per-channel write position and fill tracking
    logic [AW-1:0] r_wp   [CHANNELS];
    logic          r_wrap [CHANNELS];

    logic [CH_BITS-1:0] a_ch;
    logic [AW-1:0]      a_wp;
    logic [CW-1:0]      a_dext;
    logic [CW-1:0]      a_deff;
    logic [CW:0]        a_sum;
    logic [CW:0]        a_rpf;
    logic [AW-1:0]      a_rp;
    logic               a_hv;

    // read index: wp - D modulo MAX_DELAY, with D clamped to 1..MAX_DELAY
    always_comb begin
        a_ch   = s_axis_tuser;
        a_wp   = r_wp[a_ch];
        a_dext = CW'(r_delay);
        if (a_dext == '0) begin
            a_deff = D_ONE;
        end else if (a_dext > D_MAX) begin
            a_deff = D_MAX;
        end else begin
            a_deff = a_dext;
        end
        a_sum = (CW+1)'(a_wp) + S_MAX - (CW+1)'(a_deff);
        a_rpf = (a_sum >= S_MAX) ? a_sum - S_MAX : a_sum;
        a_rp  = a_rpf[AW-1:0];
        // entry holds data once written; otherwise it reads as zero
        a_hv  = r_wrap[a_ch] || (a_rp < a_wp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_wp[c]   <= '0;
                r_wrap[c] <= 1'b0;
            end
        end else if (s_fire) begin
            if (a_wp == WP_TOP) begin
                r_wp[a_ch]   <= '0;
                r_wrap[a_ch] <= 1'b1;
            end else begin
                r_wp[a_ch] <= a_wp + AW'(1);
            end
        end
    end

    // history memory: {input, output} per entry
    logic [2*SB-1:0] r_mem [DEPTH];
    logic [2*SB-1:0] r_rd_data;

    // compute stage registers
    logic [CH_BITS-1:0]   r_b_ch;
    logic signed [SB-1:0] r_b_x;
    logic [MAW-1:0]       r_b_raddr;
    logic [MAW-1:0]       r_b_waddr;
    logic                 r_b_hv;

    // last history write, forwarded to the read that overlaps it
    logic                 r_fw_vld;
    logic [MAW-1:0]       r_fw_addr;
    logic signed [SB-1:0] r_fw_x;
    logic signed [SB-1:0] r_fw_y;

    logic signed [SB-1:0] b_y;

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_rd_data <= r_mem[{a_ch, a_rp}];
        end
        if (b_fire) begin
            r_mem[r_b_waddr] <= {r_b_x, b_y};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld  <= 1'b0;
            r_fw_vld <= 1'b0;
        end else begin
            if (s_fire) begin
                r_b_vld <= 1'b1;
            end else if (b_fire) begin
                r_b_vld <= 1'b0;
            end
            if (b_fire) begin
                r_fw_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_b_ch    <= a_ch;
            r_b_x     <= s_axis_tdata[SB-1:0];
            r_b_raddr <= {a_ch, a_rp};
            r_b_waddr <= {a_ch, a_wp};
            r_b_hv    <= a_hv;
        end
        if (b_fire) begin
            r_fw_addr <= r_b_waddr;
            r_fw_x    <= r_b_x;
            r_fw_y    <= b_y;
        end
    end

    // allpass arithmetic: y = sat(round(a*(x - yD)) + xD)
    logic                 b_hit;
    logic signed [SB-1:0] b_xd;
    logic signed [SB-1:0] b_yd;
    logic signed [SB:0]   b_diff;
    logic signed [PW-1:0] b_prod;
    logic signed [PW-1:0] b_rnd;
    logic signed [SB+1:0] b_term;
    logic signed [SB+2:0] b_sum;

    always_comb begin
        b_hit = r_fw_vld && (r_fw_addr == r_b_raddr);
        if (b_hit) begin
            b_xd = r_fw_x;
            b_yd = r_fw_y;
        end else if (r_b_hv) begin
            b_xd = r_rd_data[2*SB-1:SB];
            b_yd = r_rd_data[SB-1:0];
        end else begin
            b_xd = '0;
            b_yd = '0;
        end
        b_diff = {r_b_x[SB-1], r_b_x} - {b_yd[SB-1], b_yd};
        b_prod = r_coef * b_diff;
        b_rnd  = b_prod + RND;
        b_term = $signed(b_rnd[PW-1:COEF_FRAC]);
        b_sum  = {b_term[SB+1], b_term} + {{3{b_xd[SB-1]}}, b_xd};
        // saturate when the top bits disagree
        if ((b_sum[SB+2:SB-1] == '0) || (b_sum[SB+2:SB-1] == '1)) begin
            b_y = b_sum[SB-1:0];
        end else if (b_sum[SB+2]) begin
            b_y = {1'b1, {(SB-1){1'b0}}};
        end else begin
            b_y = {1'b0, {(SB-1){1'b1}}};
        end
    end

    // output register
    logic [CH_BITS-1:0] r_o_ch;
    logic [SB-1:0]      r_o_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (b_fire) begin
            r_o_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_fire) begin
            r_o_ch     <= r_b_ch;
            r_o_sample <= b_y;
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tuser  = r_o_ch;
    assign m_axis_tdata  = TDW'(r_o_sample);

    // checks
    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> r_b_vld)
        else $error("accepted request did not reach the compute stage");

    a_forward_tracks_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_fire |=> (r_fw_vld && (r_fw_addr == $past(r_b_waddr))))
        else $error("forward register lost the last history write");

    a_delay_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |-> ((a_deff >= D_ONE) && (a_deff <= D_MAX) && (a_rpf < S_MAX)))
        else $error("read index out of range");

    a_stall_holds_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && !m_axis_tready) |-> !b_fire)
        else $error("compute stage overwrote a waiting result");

endmodule
